// ----- sv/mspk_pkg.sv -----
// shared types and constants of the mesh section packer
package mspk_pkg;

    localparam int ID_W   = 16;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 8;
    localparam int SECT_W = 12;

    // result kinds
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_ID   = 2'd1;
    localparam logic [1:0] ERR_SECTIONS = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRI_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_VERT_LIMIT   = 2'd2;

    typedef logic [2:0][ID_W-1:0] id_trio_t;

    // lookup result of the three corners against the vertex chain
    typedef struct packed {
        logic [2:0]            found;
        logic [2:0][IDX_W-1:0] pos;
    } lookup_t;

endpackage

// ----- sv/mesh_section_packer.sv -----
// top level of the mesh section packer: sequencer, section counters and output register
//
// Greedy section packer for pre-sorted triangles. Each input transaction carries the three
// global vertex ids of one triangle; the block looks them up in a chain of STORE_DEPTH
// cells (one compare per cell and corner, all in parallel), opens a new section when the
// triangle limit is reached or the new ids would overflow the vertex limit, then emits one
// kind-0 record per newly stored vertex followed by one kind-1 triangle record with the
// section-local corner indices (tlast set on it). A bad id or a section past MAX_SECTIONS-1
// gives a single kind-2 record with tlast. One triangle is handled at a time: the block takes
// it, does the lookup, then emits its records in order, one record per cycle when the result
// side does not stall. The result side sets the pace; the lookup itself never stalls.
// No clearing pass after reset: cells beyond the stored count are never matched.
module mesh_section_packer #(
    parameter int STORE_DEPTH  = 255,
    parameter int MAX_SECTIONS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vertex_a[15:0], vertex_b[31:16], vertex_c[47:32]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // section[11:0], global_vertex[27:12], local_a[35:28],
                                   // local_b[43:36], local_c[51:44], opens_section[52],
                                   // error_code[54:53], zero pad[55]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SEC_W    = $clog2(MAX_SECTIONS + 1);
    localparam int ID_W     = mspk_pkg::ID_W;
    localparam int IX_W     = mspk_pkg::IDX_W;
    localparam int CN_W     = mspk_pkg::CNT_W;
    localparam int SECT_W_C = mspk_pkg::SECT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // configuration registers
    logic [15:0] vertex_count_reg;
    logic [7:0]  tri_limit_reg;
    logic [7:0]  vert_limit_reg;

    // control state
    logic [1:0]       state_reg,     state_next;
    logic [CN_W-1:0]  count_reg,     count_next;
    logic [7:0]       tri_cnt_reg,   tri_cnt_next;
    logic [SEC_W-1:0] sect_reg,      sect_next;
    logic [2:0]       pend_reg,      pend_next;
    logic [1:0]       err_reg,       err_next;
    logic             opens_reg,     opens_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    mspk_pkg::id_trio_t    ids_reg, ids_next;
    logic [2:0][IX_W-1:0]  loc_reg, loc_next;
    logic [1:0]            o_kind_reg,  o_kind_next;
    logic [SECT_W_C-1:0]   o_sect_reg,  o_sect_next;
    logic [ID_W-1:0]       o_gv_reg,    o_gv_next;
    logic [2:0][IX_W-1:0]  o_loc_reg,   o_loc_next;
    logic                  o_opens_reg, o_opens_next;
    logic [1:0]            o_err_reg,   o_err_next;
    logic                  o_last_reg,  o_last_next;

    // chain interface
    logic              shift_en;
    logic [ID_W-1:0]   shift_id;
    mspk_pkg::lookup_t look;

    mspk_chain #(
        .DEPTH (STORE_DEPTH)
    ) u_chain (
        .aclk     (aclk),
        .shift_en (shift_en),
        .shift_id (shift_id),
        .count    (count_reg),
        .query    (ids_reg),
        .result   (look)
    );

    // lookup-cycle helpers
    logic [2:0]       uniq;
    logic [2:0]       fresh;
    logic [1:0]       newv;
    logic [CN_W-1:0]  tl;
    logic [CN_W-1:0]  vl;
    logic             bad_id;
    logic             need_open;
    logic             out_free;
    logic [1:0]       pick;
    logic [SECT_W_C-1:0] sect_out;

    assign out_free = !out_valid_reg || m_tready;

    // section number as reported, clipped at the last legal section
    assign sect_out = (sect_reg >= SEC_W'(MAX_SECTIONS - 1)) ?
                      SECT_W_C'(MAX_SECTIONS - 1) : SECT_W_C'(sect_reg);

    always_comb begin
        uniq[0] = 1'b1;
        uniq[1] = ids_reg[1] != ids_reg[0];
        uniq[2] = (ids_reg[2] != ids_reg[0]) && (ids_reg[2] != ids_reg[1]);
        fresh   = uniq & ~look.found;
        newv    = 2'(fresh[0]) + 2'(fresh[1]) + 2'(fresh[2]);
        tl      = (tri_limit_reg == 8'd0) ? 8'd1 : tri_limit_reg;
        if (vert_limit_reg < 8'd3) begin
            vl = 8'd3;
        end else if (32'(vert_limit_reg) > STORE_DEPTH) begin
            vl = CN_W'(STORE_DEPTH);
        end else begin
            vl = vert_limit_reg;
        end
        bad_id = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (ids_reg[k] >= vertex_count_reg) begin
                bad_id = 1'b1;
            end
        end
        need_open = (tri_cnt_reg != 8'd0) &&
                    ((tri_cnt_reg >= tl) || ({1'b0, count_reg} + 9'(newv) > {1'b0, vl}));
        // first pending new vertex in corner order
        if (pend_reg[0]) begin
            pick = 2'd0;
        end else if (pend_reg[1]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        tri_cnt_next   = tri_cnt_reg;
        sect_next      = sect_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        opens_next     = opens_reg;
        ids_next       = ids_reg;
        loc_next       = loc_reg;
        out_valid_next = out_valid_reg;
        o_kind_next    = o_kind_reg;
        o_sect_next    = o_sect_reg;
        o_gv_next      = o_gv_reg;
        o_loc_next     = o_loc_reg;
        o_opens_next   = o_opens_reg;
        o_err_next     = o_err_reg;
        o_last_next    = o_last_reg;
        shift_en       = 1'b0;
        shift_id       = ids_reg[pick];

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ids_next[0] = s_tdata[15:0];
                    ids_next[1] = s_tdata[31:16];
                    ids_next[2] = s_tdata[47:32];
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_EMIT;
                pend_next  = '0;
                err_next   = mspk_pkg::ERR_NONE;
                opens_next = (tri_cnt_reg == 8'd0);
                // indices of corners already in the section
                for (int k = 0; k < 3; k++) begin
                    loc_next[k] = IX_W'(count_reg - CN_W'(1) - CN_W'(look.pos[k]));
                end
                if (bad_id) begin
                    err_next = mspk_pkg::ERR_BAD_ID;
                end else if (32'(sect_reg) >= MAX_SECTIONS) begin
                    err_next = mspk_pkg::ERR_SECTIONS;
                end else if (need_open) begin
                    if (32'(sect_reg) + 1 >= MAX_SECTIONS) begin
                        sect_next = SEC_W'(MAX_SECTIONS);
                        err_next  = mspk_pkg::ERR_SECTIONS;
                    end else begin
                        sect_next    = sect_reg + SEC_W'(1);
                        count_next   = '0;
                        tri_cnt_next = '0;
                        opens_next   = 1'b1;
                        pend_next    = uniq;
                    end
                end else begin
                    pend_next = fresh;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (err_reg != mspk_pkg::ERR_NONE) begin
                        out_valid_next = 1'b1;
                        o_kind_next    = mspk_pkg::KIND_ERROR;
                        o_sect_next    = sect_out;
                        o_gv_next      = '0;
                        o_loc_next     = '0;
                        o_opens_next   = 1'b0;
                        o_err_next     = err_reg;
                        o_last_next    = 1'b1;
                        state_next     = ST_IDLE;
                    end else if (pend_reg != 3'b000) begin
                        pend_next[pick] = 1'b0;
                        if (32'(count_reg) < STORE_DEPTH) begin
                            // store the vertex and give every equal corner its index
                            shift_en       = 1'b1;
                            out_valid_next = 1'b1;
                            o_kind_next    = mspk_pkg::KIND_VERTEX;
                            o_sect_next    = sect_out;
                            o_gv_next      = ids_reg[pick];
                            o_loc_next     = '0;
                            o_loc_next[0]  = IX_W'(count_reg);
                            o_opens_next   = opens_reg;
                            o_err_next     = mspk_pkg::ERR_NONE;
                            o_last_next    = 1'b0;
                            count_next     = count_reg + CN_W'(1);
                            for (int k = 0; k < 3; k++) begin
                                if (ids_reg[k] == ids_reg[pick]) begin
                                    loc_next[k] = IX_W'(count_reg);
                                end
                            end
                        end
                    end else begin
                        out_valid_next = 1'b1;
                        o_kind_next    = mspk_pkg::KIND_TRIANGLE;
                        o_sect_next    = sect_out;
                        o_gv_next      = '0;
                        o_loc_next     = loc_reg;
                        o_opens_next   = opens_reg;
                        o_err_next     = mspk_pkg::ERR_NONE;
                        o_last_next    = 1'b1;
                        if (tri_cnt_reg != 8'hFF) begin
                            tri_cnt_next = tri_cnt_reg + 8'd1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            tri_cnt_reg      <= '0;
            sect_reg         <= '0;
            pend_reg         <= '0;
            err_reg          <= mspk_pkg::ERR_NONE;
            opens_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= 16'hFFFF;
            tri_limit_reg    <= 8'hFF;
            vert_limit_reg   <= 8'hFF;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tri_cnt_reg   <= tri_cnt_next;
            sect_reg      <= sect_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            opens_reg     <= opens_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    mspk_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                    mspk_pkg::CFG_TRI_LIMIT:    tri_limit_reg    <= cfg_data[7:0];
                    mspk_pkg::CFG_VERT_LIMIT:   vert_limit_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ids_reg     <= ids_next;
        loc_reg     <= loc_next;
        o_kind_reg  <= o_kind_next;
        o_sect_reg  <= o_sect_next;
        o_gv_reg    <= o_gv_next;
        o_loc_reg   <= o_loc_next;
        o_opens_reg <= o_opens_next;
        o_err_reg   <= o_err_next;
        o_last_reg  <= o_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {1'b0, o_err_reg, o_opens_reg, o_loc_reg[2], o_loc_reg[1],
                       o_loc_reg[0], o_gv_reg, o_sect_reg};

endmodule

// ----- sv/mspk_cell.sv -----
// one cell of the vertex chain: holds one stored id and compares it to the corners
module mspk_cell (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [mspk_pkg::ID_W-1:0]     id_in,
    input  logic                          live,
    input  mspk_pkg::id_trio_t            query,
    output logic [mspk_pkg::ID_W-1:0]     id_out,
    output logic [2:0]                    hit
);

    logic [mspk_pkg::ID_W-1:0] id_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            id_reg <= id_in;
        end
    end

    assign id_out = id_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hit[k] = live && (id_reg == query[k]);
        end
    end

endmodule

// ----- sv/mspk_chain.sv -----
// row of vertex cells; a new id enters at cell 0 and older ids move one cell along
module mspk_chain #(
    parameter int DEPTH = 255
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [mspk_pkg::ID_W-1:0]     shift_id,
    input  logic [mspk_pkg::CNT_W-1:0]    count,
    input  mspk_pkg::id_trio_t            query,
    output mspk_pkg::lookup_t             result
);

    logic [DEPTH:0][mspk_pkg::ID_W-1:0] link;
    logic [DEPTH-1:0][2:0]              hit;

    assign link[0] = shift_id;

    for (genvar p = 0; p < DEPTH; p++) begin : g_cell
        mspk_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .id_in    (link[p]),
            .live     (mspk_pkg::CNT_W'(p) < count),
            .query    (query),
            .id_out   (link[p+1]),
            .hit      (hit[p])
        );
    end

    // ids in the chain are distinct, so at most one cell hits per corner
    always_comb begin
        result = '0;
        for (int p = 0; p < DEPTH; p++) begin
            for (int k = 0; k < 3; k++) begin
                if (hit[p][k]) begin
                    result.found[k] = 1'b1;
                    result.pos[k]   = result.pos[k] | mspk_pkg::IDX_W'(p);
                end
            end
        end
    end

endmodule
